[sv/tcda_pkg.sv]
// Shared types, status codes and the class order function for the two-class
// direction arbiter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcda_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_CLASSES     = 4;
	localparam int ID_W            = 8;
	localparam int TIME_W          = 8;
	localparam int CLASS_W         = 2;
	localparam int ENTRY_W         = ID_W + TIME_W;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_GRANTED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic {
		KIND_ARRIVE = 1'b0,
		KIND_GRANT  = 1'b1
	} kind_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;     // item taken from the ports this cycle
		logic grant_fin;  // store read data valid, deliver the grant
	} ctrl_cmd_t;

	typedef struct packed {
		logic grant_hit;  // some class holds a request
	} dp_stat_t;

	// class tried at position pos: 0,1,2,3 after west, 1,0,3,2 after east
	function automatic logic [CLASS_W-1:0] order_class(input logic after_east,
		input logic [CLASS_W-1:0] pos);
		order_class = after_east ? {pos[1], ~pos[0]} : pos;
	endfunction

endpackage

`default_nettype wire

[sv/two_class_direction_arbiter.sv]
// Top level of the two-class direction arbiter: controller plus datapath.
// Depends on tcda_pkg, tcda_ctrl, tcda_datapath.
//
//  channel  | handshake        | payload
//  ---------+------------------+--------------------------------------------
//  request  | start / busy     | kind, req_id, req_class, service_time
//  result   | done (one cycle) | status, grant_id, grant_class, grant_time
//
// An item is taken when start is high and busy low. Arrivals and grants
// with nothing waiting put their result on done the next cycle and never
// raise busy. A grant that finds a request reads the request store
// (registered read) and waits in S_GRANT meanwhile: busy is high for one cycle.
// Reset clears pointers, counts and direction; the store needs no clearing.
// The receiver cannot stall; each result is shown for one cycle.
`timescale 1ns / 1ps
`default_nettype none

module two_class_direction_arbiter #(
	parameter int QUEUE_DEPTH = tcda_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          kind,
	input  wire logic [tcda_pkg::ID_W-1:0]     req_id,
	input  wire logic [tcda_pkg::CLASS_W-1:0]  req_class,
	input  wire logic [tcda_pkg::TIME_W-1:0]   service_time,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [tcda_pkg::ID_W-1:0]          grant_id,
	output logic [tcda_pkg::CLASS_W-1:0]       grant_class,
	output logic [tcda_pkg::TIME_W-1:0]        grant_time
);

	import tcda_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	tcda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	tcda_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.kind         (kind),
		.req_id       (req_id),
		.req_class    (req_class),
		.service_time (service_time),
		.done         (done),
		.status       (status),
		.grant_id     (grant_id),
		.grant_class  (grant_class),
		.grant_time   (grant_time)
	);

endmodule

`default_nettype wire

[sv/tcda_ram.sv]
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcda_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/tcda_ctrl.sv]
// Controller for the arbiter: idle / grant-read sequencing and busy.
// Depends on tcda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcda_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 kind,
	input  wire tcda_pkg::dp_stat_t   stat,
	output logic                      busy,
	output tcda_pkg::ctrl_cmd_t       cmd
);

	import tcda_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_GRANT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   take;

	assign take = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// a grant that found a request waits in S_GRANT for the store's registered read
					if (take && (kind == KIND_GRANT) && stat.grant_hit) begin
						state_q <= S_GRANT;
						busy_q  <= 1'b1;
					end
				end
				S_GRANT: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd.accept    = take;
		cmd.grant_fin = (state_q == S_GRANT);
	end

	assign busy = busy_q;

endmodule

`default_nettype wire

[sv/tcda_datapath.sv]
// Datapath: per-class head pointers and counts, request store, class pick
// and result registers. Depends on tcda_pkg, tcda_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcda_datapath #(
	parameter int QUEUE_DEPTH = tcda_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tcda_pkg::ctrl_cmd_t           cmd,
	output tcda_pkg::dp_stat_t                 stat,
	input  wire logic                          kind,
	input  wire logic [tcda_pkg::ID_W-1:0]     req_id,
	input  wire logic [tcda_pkg::CLASS_W-1:0]  req_class,
	input  wire logic [tcda_pkg::TIME_W-1:0]   service_time,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [tcda_pkg::ID_W-1:0]          grant_id,
	output logic [tcda_pkg::CLASS_W-1:0]       grant_class,
	output logic [tcda_pkg::TIME_W-1:0]        grant_time
);

	import tcda_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = CLASS_W + PW;
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(QUEUE_DEPTH);

	logic [PW-1:0]      heads_q  [NUM_CLASSES];
	logic [CW-1:0]      counts_q [NUM_CLASSES];
	logic               last_east_q;
	logic [CLASS_W-1:0] gcls_q;

	logic               done_q;
	status_t            status_q;
	logic [ID_W-1:0]    gid_q;
	logic [CLASS_W-1:0] gcls_out_q;
	logic [TIME_W-1:0]  gtime_q;

	logic [CW-1:0]      arr_cnt;
	logic [PW-1:0]      arr_head;
	logic               arr_full;
	logic [PW:0]        tail_sum;
	logic [PW-1:0]      tail_idx;

	logic               hit;
	logic [CLASS_W-1:0] sel;
	logic [CLASS_W-1:0] cand;
	logic [PW-1:0]      sel_head;
	logic [PW:0]        head_inc;
	logic [PW-1:0]      head_nxt;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// enqueue side
	always_comb begin
		arr_cnt  = counts_q[req_class];
		arr_head = heads_q[req_class];
		arr_full = (arr_cnt == FULL_CNT);
		tail_sum = (PW + 1)'(arr_head) + (PW + 1)'(arr_cnt);
		if (tail_sum >= DEPTH_W) begin
			tail_sum = tail_sum - DEPTH_W;
		end
		tail_idx = tail_sum[PW-1:0];
	end

	// pick the first non-empty class in the current order
	always_comb begin
		hit  = 1'b0;
		sel  = '0;
		cand = '0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			cand = order_class(last_east_q, CLASS_W'(i));
			if (!hit && (counts_q[cand] != '0)) begin
				hit = 1'b1;
				sel = cand;
			end
		end
		sel_head = heads_q[sel];
		head_inc = (PW + 1)'(sel_head) + (PW + 1)'(1);
		head_nxt = (head_inc == DEPTH_W) ? '0 : head_inc[PW-1:0];
	end

	assign stat.grant_hit = hit;

	assign ram_we    = cmd.accept && (kind == KIND_ARRIVE) && !arr_full;
	assign ram_waddr = {req_class, tail_idx};
	assign ram_raddr = {sel, sel_head};

	tcda_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_CLASSES << PW)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({req_id, service_time}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				heads_q[c]  <= '0;
				counts_q[c] <= '0;
			end
			last_east_q <= 1'b0;
		end else if (cmd.accept) begin
			if (kind == KIND_ARRIVE) begin
				if (!arr_full) begin
					counts_q[req_class] <= arr_cnt + CW'(1);
				end
			end else if (hit) begin
				heads_q[sel]  <= head_nxt;
				counts_q[sel] <= counts_q[sel] - CW'(1);
				last_east_q   <= ~sel[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			gcls_q <= sel;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.grant_fin ||
				(cmd.accept && ((kind == KIND_ARRIVE) || !hit));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.grant_fin) begin
			status_q   <= ST_GRANTED;
			gid_q      <= ram_rdata[ENTRY_W-1:TIME_W];
			gcls_out_q <= gcls_q;
			gtime_q    <= ram_rdata[TIME_W-1:0];
		end else if (cmd.accept) begin
			if (kind == KIND_ARRIVE) begin
				status_q <= arr_full ? ST_DROPPED : ST_ACCEPTED;
			end else begin
				status_q <= ST_EMPTY;
			end
			gid_q      <= '0;
			gcls_out_q <= '0;
			gtime_q    <= '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign grant_id    = gid_q;
	assign grant_class = gcls_out_q;
	assign grant_time  = gtime_q;

endmodule

`default_nettype wire
